### rtl/fdrq_pkg.sv
// ----------------------------------------------------------------------------
// fdrq_pkg
// Shared types and codes of the display-order frame queue: entry layout,
// operation and status codes, reset values.
// ----------------------------------------------------------------------------
package fdrq_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned THR_W           = 5;
  localparam int unsigned DEPTH_W         = 5;
  localparam logic [THR_W-1:0] THR_RESET  = THR_W'(4);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_FILTERED = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // flags: bit0 format, bit1 pts valid, bit2 dts valid
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] pts;
    logic [63:0] dts;
    logic [2:0]  flags;
    logic [31:0] handle;
  } entry_t;

endpackage

### rtl/fdrq_ram.sv
// ----------------------------------------------------------------------------
// fdrq_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module fdrq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/frame_display_reorder_queue.sv
// ----------------------------------------------------------------------------
// frame_display_reorder_queue
// Holds decoded frames in display order and hands them out one by one.
// ----------------------------------------------------------------------------
// Frames live in one RAM used as a ring (head pointer, tail pointer, count).
// An insert walks back from the tail one entry per cycle through the single
// RAM read port, moving each entry with a larger key up one slot, then
// writes the new entry into the freed slot. A pop reads the head slot;
// flush, rejected inserts and empty pops touch no RAM. A result waits in
// its state until the output is free. One beat is worked on at a time; a new
// beat is taken while the previous result still waits at the output. There
// is no clearing pass after reset. The user must write ready_threshold through
// cfg_we_i / cfg_wdata_i only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module frame_display_reorder_queue
  import fdrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [THR_W-1:0]    cfg_wdata_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  input  logic [31:0]         frame_handle_i,
  input  logic                image_present_i,
  input  logic [1:0]          pixel_format_i,
  input  logic                frame_dropped_i,
  input  logic signed [63:0]  pts_i,
  input  logic                pts_valid_i,
  input  logic signed [63:0]  dts_i,
  input  logic                dts_valid_i,
  input  logic signed [63:0]  arrival_time_i,

  output logic                res_valid_o,
  input  logic                res_stall_i,
  output logic [1:0]          status_o,
  output logic                out_valid_o,
  output logic [31:0]         out_handle_o,
  output logic                out_format_o,
  output logic signed [63:0]  out_pts_o,
  output logic                out_pts_valid_o,
  output logic signed [63:0]  out_dts_o,
  output logic                out_dts_valid_o,
  output logic [DEPTH_W-1:0]  queue_depth_o,
  output logic                picture_ready_o
);

  localparam int unsigned AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (CW > THR_W) ? CW : THR_W;
  localparam int unsigned EW    = $bits(entry_t);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_POP,
    S_FINISH
  } state_e;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_IDX : p - 1'b1;
  endfunction

  state_e          state_q;
  logic [AW-1:0]   head_q, tail_q, wp_q, rp_q;
  logic [CW-1:0]   count_q, idx_q;
  logic [THR_W-1:0] thr_q;
  entry_t          new_q;
  logic [1:0]      st_status_q;

  logic            res_valid_q;
  logic [1:0]      status_q;
  logic            out_valid_q;
  logic [31:0]     out_handle_q;
  logic            out_format_q;
  logic [63:0]     out_pts_q;
  logic            out_pts_valid_q;
  logic [63:0]     out_dts_q;
  logic            out_dts_valid_q;
  logic [DEPTH_W-1:0] queue_depth_q;
  logic            picture_ready_q;

  logic            accept, keep, full, empty, out_free, greater;
  entry_t          in_entry, rd_entry;
  logic [EW-1:0]   ram_rdata, ram_wdata;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [CMP_W-1:0] count_ext;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign keep     = image_present_i && !pixel_format_i[1] && !frame_dropped_i;
  assign full     = (count_q == FULL_CNT);
  assign empty    = (count_q == '0);
  assign out_free = !res_valid_q || !res_stall_i;
  assign rd_entry = entry_t'(ram_rdata);
  assign greater  = $signed(rd_entry.key) > $signed(new_q.key);
  assign count_ext = CMP_W'(count_q);

  always_comb begin
    in_entry.key    = pts_valid_i ? pts_i : (dts_valid_i ? dts_i : arrival_time_i);
    in_entry.pts    = pts_i;
    in_entry.dts    = dts_i;
    in_entry.flags  = {dts_valid_i, pts_valid_i, pixel_format_i[0]};
    in_entry.handle = frame_handle_i;
  end

  // ram port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr_dec(tail_q);
    ram_we    = 1'b0;
    ram_waddr = wp_q;
    ram_wdata = EW'(new_q);
    case (state_q)
      S_IDLE: begin
        if (accept && op_i == OP_INSERT && keep && !full && !empty) begin
          ram_re = 1'b1;
        end else if (accept && op_i == OP_POP && !empty) begin
          ram_re    = 1'b1;
          ram_raddr = head_q;
        end
      end
      S_SCAN: begin
        ram_we = 1'b1;
        if (greater) begin
          ram_wdata = ram_rdata;
          if (idx_q != CW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = ptr_dec(rp_q);
          end
        end
      end
      S_PLACE: ram_we = 1'b1;
      default: ;
    endcase
  end

  fdrq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      thr_q       <= THR_RESET;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (res_valid_q && !res_stall_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q     <= S_FINISH;
            st_status_q <= ST_OK;
            case (op_i)
              OP_INSERT: begin
                if (!keep) begin
                  st_status_q <= ST_FILTERED;
                end else if (full) begin
                  st_status_q <= ST_FULL;
                end else begin
                  new_q   <= in_entry;
                  wp_q    <= tail_q;
                  rp_q    <= ptr_dec(tail_q);
                  idx_q   <= count_q;
                  tail_q  <= ptr_inc(tail_q);
                  count_q <= count_q + 1'b1;
                  state_q <= empty ? S_PLACE : S_SCAN;
                end
              end
              OP_POP: begin
                if (empty) begin
                  st_status_q <= ST_EMPTY;
                end else begin
                  head_q  <= ptr_inc(head_q);
                  count_q <= count_q - 1'b1;
                  state_q <= S_POP;
                end
              end
              OP_FLUSH: begin
                count_q <= '0;
                tail_q  <= head_q;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (greater) begin
            wp_q  <= rp_q;
            rp_q  <= ptr_dec(rp_q);
            idx_q <= idx_q - 1'b1;
            if (idx_q == CW'(1)) begin
              state_q <= S_PLACE;
            end
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_PLACE: begin
          state_q <= S_FINISH;
        end
        S_POP: begin
          if (out_free) begin
            res_valid_q     <= 1'b1;
            status_q        <= ST_OK;
            out_valid_q     <= 1'b1;
            out_handle_q    <= rd_entry.handle;
            out_format_q    <= rd_entry.flags[0];
            out_pts_q       <= rd_entry.pts;
            out_pts_valid_q <= rd_entry.flags[1];
            out_dts_q       <= rd_entry.dts;
            out_dts_valid_q <= rd_entry.flags[2];
            queue_depth_q   <= count_ext[DEPTH_W-1:0];
            picture_ready_q <= count_ext >= CMP_W'(thr_q);
            state_q         <= S_IDLE;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            res_valid_q     <= 1'b1;
            status_q        <= st_status_q;
            out_valid_q     <= 1'b0;
            out_handle_q    <= '0;
            out_format_q    <= 1'b0;
            out_pts_q       <= '0;
            out_pts_valid_q <= 1'b0;
            out_dts_q       <= '0;
            out_dts_valid_q <= 1'b0;
            queue_depth_q   <= count_ext[DEPTH_W-1:0];
            picture_ready_q <= count_ext >= CMP_W'(thr_q);
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign res_valid_o     = res_valid_q;
  assign status_o        = status_q;
  assign out_valid_o     = out_valid_q;
  assign out_handle_o    = out_handle_q;
  assign out_format_o    = out_format_q;
  assign out_pts_o       = out_pts_q;
  assign out_pts_valid_o = out_pts_valid_q;
  assign out_dts_o       = out_dts_q;
  assign out_dts_valid_o = out_dts_valid_q;
  assign queue_depth_o   = queue_depth_q;
  assign picture_ready_o = picture_ready_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count above queue depth");

  a_ring_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FULL_CNT) |-> head_q == tail_q)
    else $error("ring pointers disagree with entry count");

  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> idx_q != '0)
    else $error("insert scan past the head");

  a_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && out_valid_o) |-> status_o == ST_OK)
    else $error("popped frame with bad status");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q != S_IDLE)
    else $error("beat accepted without work");

endmodule
